### hdl/dsu_pkg.sv
// Shared types and constants for the page-string to UTF-8 transcoder.
// No dependencies; every module of the block imports this package.
package dsu_pkg;

   localparam int MAX_PAGE_BYTES_DEF = 65536;
   localparam int CMDQ_DEPTH_DEF     = 4;

   localparam logic [15:0] CAP_RESET      = 16'd256;
   localparam logic [7:0]  KIND_LONG_ASCII = 8'h40;
   localparam logic [7:0]  KIND_UTF16      = 8'h90;
   localparam logic [7:0]  UTF8_LEAD2      = 8'hc0;
   localparam logic [7:0]  UTF8_LEAD3      = 8'he0;
   localparam logic [7:0]  UTF8_CONT       = 8'h80;
   localparam logic [15:0] LONG_HDR_BYTES  = 16'd4;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_HDR  = 2'd1,
      STATUS_OFF_PAGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_HEADER = 3'b010,
      PH_BODY   = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0]  in_byte;
      logic        first;
      logic [16:0] page_avail;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        done_res;
      logic [1:0]  status;
      logic [15:0] out_length;
   } rsp_type;

   // one decoded item: up to three bytes, then an optional done beat
   typedef struct packed {
      logic [1:0]  nbytes;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic        done;
      status_type  status;
      logic [15:0] length;
   } cmd_type;

endpackage

### hdl/dsu_front.sv
// Front end: accepts record bytes, walks the header/body state and
// decides the UTF-8 bytes and done beat of each item. Uses dsu_pkg.
module dsu_front import dsu_pkg::*; #(
   parameter int MAX_PAGE_BYTES = MAX_PAGE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req,
   input  logic [15:0] capacity,
   output logic        cmd_push,
   output cmd_type     cmd
);

   localparam int PAGE_W = $clog2(MAX_PAGE_BYTES + 1);
   localparam logic [16:0] MAX_PAGE = 17'(MAX_PAGE_BYTES);

   phase_type          phase_ff, phase_in;
   logic               utf16_ff, utf16_in;
   logic [1:0]         hcount_ff, hcount_in;
   logic [15:0]        body_ff, body_in;
   logic [7:0]         low_ff, low_in;
   logic               half_ff, half_in;
   logic [15:0]        emit_ff, emit_in;
   logic [PAGE_W-1:0]  page_ff, page_in;

   logic [16:0] sat;
   logic [6:0]  total;
   logic [15:0] bl;
   logic [15:0] cp;
   logic [1:0]  need;
   logic        done_flag;
   status_type  done_st;

   function automatic logic finished(input logic [15:0] emitted, input logic is16,
                                     input logic [15:0] left, input logic [15:0] cap);
      logic full_out;
      full_out = ({1'b0, emitted} + 17'd1) >= {1'b0, cap};
      return full_out || (is16 ? (left < 16'd2) : (left == 16'd0));
   endfunction

   always_comb begin
      phase_in  = phase_ff;
      utf16_in  = utf16_ff;
      hcount_in = hcount_ff;
      body_in   = body_ff;
      low_in    = low_ff;
      half_in   = half_ff;
      emit_in   = emit_ff;
      page_in   = page_ff;
      done_flag = 1'b0;
      done_st   = STATUS_OK;
      cmd       = '0;
      sat   = (req.page_avail > MAX_PAGE) ? MAX_PAGE : req.page_avail;
      total = req.in_byte[7:1];
      bl    = body_ff - {15'd0, (body_ff != 16'd0)};
      cp    = {req.in_byte, low_ff};
      need  = (cp < 16'h0080) ? 2'd1 : ((cp < 16'h0800) ? 2'd2 : 2'd3);
      if (accept) begin
         if (req.first) begin
            page_in   = PAGE_W'(sat);
            emit_in   = '0;
            hcount_in = '0;
            body_in   = '0;
            half_in   = 1'b0;
            low_in    = '0;
            phase_in  = PH_IDLE;
            if (capacity == 16'd0) begin
               done_flag = 1'b1;
               done_st   = STATUS_BAD_HDR;
            end else if (sat == 17'd0) begin
               done_flag = 1'b1;
               done_st   = STATUS_OFF_PAGE;
            end else if (req.in_byte == KIND_LONG_ASCII || req.in_byte == KIND_UTF16) begin
               utf16_in = (req.in_byte == KIND_UTF16);
               if (sat < 17'd4) begin
                  done_flag = 1'b1;
                  done_st   = STATUS_OFF_PAGE;
               end else begin
                  phase_in = PH_HEADER;
               end
            end else begin
               utf16_in = 1'b0;
               if (total == 7'd0) begin
                  done_flag = 1'b1;
                  done_st   = STATUS_BAD_HDR;
               end else if (17'(total) > sat) begin
                  done_flag = 1'b1;
                  done_st   = STATUS_OFF_PAGE;
               end else begin
                  body_in  = 16'(total) - 16'd1;
                  phase_in = PH_BODY;
                  if (finished(16'd0, 1'b0, 16'(total) - 16'd1, capacity)) begin
                     done_flag = 1'b1;
                  end
               end
            end
         end else if (phase_ff == PH_HEADER) begin
            case (hcount_ff)
               2'd0: begin
                  body_in   = {8'd0, req.in_byte};
                  hcount_in = 2'd1;
               end
               2'd1: begin
                  body_in   = {req.in_byte, body_ff[7:0]};
                  hcount_in = 2'd2;
               end
               default: begin
                  hcount_in = 2'd0;
                  if (body_ff < LONG_HDR_BYTES) begin
                     done_flag = 1'b1;
                     done_st   = STATUS_BAD_HDR;
                  end else if (17'(body_ff) > 17'(page_ff)) begin
                     done_flag = 1'b1;
                     done_st   = STATUS_OFF_PAGE;
                  end else begin
                     body_in  = body_ff - LONG_HDR_BYTES;
                     phase_in = PH_BODY;
                     if (finished(16'd0, utf16_ff, body_ff - LONG_HDR_BYTES, capacity)) begin
                        done_flag = 1'b1;
                     end
                  end
               end
            endcase
         end else if (phase_ff == PH_BODY) begin
            body_in = bl;
            if (!utf16_ff) begin
               if (req.in_byte == 8'd0) begin
                  done_flag = 1'b1;
               end else begin
                  cmd.nbytes = 2'd1;
                  cmd.byte0  = req.in_byte;
                  emit_in    = emit_ff + 16'd1;
                  if (finished(emit_ff + 16'd1, 1'b0, bl, capacity)) begin
                     done_flag = 1'b1;
                  end
               end
            end else if (!half_ff) begin
               low_in  = req.in_byte;
               half_in = 1'b1;
            end else begin
               half_in = 1'b0;
               if (cp == 16'd0 ||
                   ({1'b0, emit_ff} + 17'(need)) >= {1'b0, capacity}) begin
                  done_flag = 1'b1;
               end else begin
                  cmd.nbytes = need;
                  emit_in    = emit_ff + 16'(need);
                  case (need)
                     2'd1: begin
                        cmd.byte0 = cp[7:0];
                     end
                     2'd2: begin
                        cmd.byte0 = UTF8_LEAD2 | {3'd0, cp[10:6]};
                        cmd.byte1 = UTF8_CONT | {2'd0, cp[5:0]};
                     end
                     default: begin
                        cmd.byte0 = UTF8_LEAD3 | {4'd0, cp[15:12]};
                        cmd.byte1 = UTF8_CONT | {2'd0, cp[11:6]};
                        cmd.byte2 = UTF8_CONT | {2'd0, cp[5:0]};
                     end
                  endcase
                  if (finished(emit_ff + 16'(need), 1'b1, bl, capacity)) begin
                     done_flag = 1'b1;
                  end
               end
            end
         end
      end
      if (done_flag) begin
         phase_in   = PH_IDLE;
         cmd.done   = 1'b1;
         cmd.status = done_st;
         cmd.length = (done_st == STATUS_OK) ? emit_in : 16'd0;
      end
      cmd_push = (cmd.nbytes != 2'd0) || done_flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         utf16_ff  <= 1'b0;
         hcount_ff <= '0;
         body_ff   <= '0;
         low_ff    <= '0;
         half_ff   <= 1'b0;
         emit_ff   <= '0;
         page_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         utf16_ff  <= utf16_in;
         hcount_ff <= hcount_in;
         body_ff   <= body_in;
         low_ff    <= low_in;
         half_ff   <= half_in;
         emit_ff   <= emit_in;
         page_ff   <= page_in;
      end
   end

endmodule

### hdl/dsu_cmdq.sv
// Short command queue between front and back end.
// Uses dsu_pkg for the command type.
module dsu_cmdq import dsu_pkg::*; #(
   parameter int DEPTH = CMDQ_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   cmd_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, rd_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == LAST) ? '0 : wr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == LAST) ? '0 : rd_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

### hdl/dsu_back.sv
// Back end: expands each command into byte and done beats, one a cycle
// while the registered result stage can take one. Uses dsu_pkg.
module dsu_back import dsu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  cmd_type q_data,
   output logic    q_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   cmd_type    cur_ff;
   logic       cur_valid_ff;
   logic [1:0] idx_ff;
   rsp_type    rsp_ff;
   logic       rsp_valid_ff;

   logic    load, emit, last;
   rsp_type beat;

   assign load  = !rsp_valid_ff || rsp_pop;
   assign emit  = cur_valid_ff && load;
   assign last  = cur_ff.done ? (idx_ff == cur_ff.nbytes) : (2'(idx_ff + 2'd1) == cur_ff.nbytes);
   assign q_pop = !q_empty && (!cur_valid_ff || (emit && last));

   always_comb begin
      beat = '0;
      if (idx_ff < cur_ff.nbytes) begin
         beat.byte_valid = 1'b1;
         case (idx_ff)
            2'd0:    beat.out_byte = cur_ff.byte0;
            2'd1:    beat.out_byte = cur_ff.byte1;
            default: beat.out_byte = cur_ff.byte2;
         endcase
      end else begin
         beat.done_res   = 1'b1;
         beat.status     = cur_ff.status;
         beat.out_length = cur_ff.length;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_data;
      end
      if (emit) begin
         rsp_ff <= beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            cur_valid_ff <= 1'b1;
            idx_ff       <= '0;
         end else if (emit && last) begin
            cur_valid_ff <= 1'b0;
         end else if (emit) begin
            idx_ff <= idx_ff + 2'd1;
         end
         if (load) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hdl/devicesql_string_to_utf8.sv
// Page-string record to UTF-8 transcoder, top level.
// Items pass the command queue, the back end's current command and the result
// register in order. Throughput: one item accepted per cycle while the command
// queue has room; the back end delivers one result beat per cycle while rsp_pop keeps up.
// Reset: synchronous; clears all control state and sets the capacity register to 256.
// Holds the capacity register; instantiates dsu_front, dsu_cmdq, dsu_back (dsu_pkg).
module devicesql_string_to_utf8 import dsu_pkg::*; #(
   parameter int MAX_PAGE_BYTES = MAX_PAGE_BYTES_DEF,
   parameter int CMDQ_DEPTH     = CMDQ_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic [15:0] cap_ff;
   logic        accept;
   logic        cmd_push, q_full, q_empty, q_pop;
   cmd_type     cmd, q_data;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_data;
      end
   end

   dsu_front #(.MAX_PAGE_BYTES(MAX_PAGE_BYTES)) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .capacity (cap_ff),
      .cmd_push (cmd_push),
      .cmd      (cmd)
   );

   dsu_cmdq #(.DEPTH(CMDQ_DEPTH)) u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   dsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !q_full)
      else $error("command pushed into full queue");

   a_error_len_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.done_res && rsp_data.status != STATUS_OK)
         |-> rsp_data.out_length == 16'd0)
      else $error("error done beat carries a length");

   a_beat_kind: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.byte_valid != rsp_data.done_res))
      else $error("result beat is neither a byte nor a done");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result pending right after reset");
`endif

endmodule
